/* src/rvh_pkg.sv */
// shared constants, types and codes for the rv32i subset hart
package rvh_pkg;

    localparam int unsigned MEM_BYTES = 65536;
    localparam int unsigned MEM_WORDS = MEM_BYTES / 4;
    localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_PRELOAD = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    localparam logic [1:0] HALT_NONE    = 2'd0;
    localparam logic [1:0] HALT_ALIGN   = 2'd1;
    localparam logic [1:0] HALT_ILLEGAL = 2'd2;

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;
    localparam logic [2:0] F3_ADDI = 3'd0;
    localparam logic [2:0] F3_B    = 3'd0;
    localparam logic [2:0] F3_H    = 3'd1;
    localparam logic [2:0] F3_W    = 3'd2;
    localparam logic [2:0] F3_BU   = 3'd4;
    localparam logic [2:0] F3_HU   = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDMEM,
        ST_FETCH,
        ST_EXEC,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic        rd_en;
        logic        wr_en;
        logic [3:0]  wr_mask;
        logic [31:0] addr;
        logic [31:0] wr_data;
    } mem_req_t;

    typedef struct packed {
        logic        rd_en;
        logic [4:0]  ra_a;
        logic [4:0]  ra_b;
        logic        we;
        logic [4:0]  wa;
        logic [31:0] wd;
    } rf_req_t;

endpackage

/* src/rvh_mem.sv */
// byte memory in four byte lanes, any four consecutive bytes per access
module rvh_mem (
    input  logic              clk,
    input  rvh_pkg::mem_req_t req,
    output logic [31:0]       rdata
);
    import rvh_pkg::*;

    logic [7:0] rd_q [4];
    logic [3:0] inr_q;
    logic [1:0] lo_q;

    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        logic [7:0]  mem [MEM_WORDS];
        logic [1:0]  rel;
        logic [31:0] ba;
        logic        inr;

        assign rel = 2'(k) - req.addr[1:0];
        assign ba  = req.addr + {30'b0, rel};
        assign inr = ba < 32'(MEM_BYTES);

        always_ff @(posedge clk)
        begin
            if (req.wr_en && req.wr_mask[rel] && inr)
            begin
                mem[ba[MEM_AW+1:2]] <= req.wr_data[8*rel +: 8];
            end
            if (req.rd_en)
            begin
                rd_q[k]  <= mem[ba[MEM_AW+1:2]];
                inr_q[k] <= inr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            lo_q <= req.addr[1:0];
        end
    end

    always_comb
    begin
        logic [1:0] bk;
        for (int i = 0; i < 4; i++)
        begin
            bk = lo_q + 2'(i);
            rdata[8*i +: 8] = inr_q[bk] ? rd_q[bk] : 8'h00;
        end
    end

endmodule

/* src/rvh_rf.sv */
// register file, two read copies with registered read, valid bits for reset
module rvh_rf (
    input  logic             clk,
    input  logic             rst_n,
    input  rvh_pkg::rf_req_t req,
    output logic [31:0]      rd_a,
    output logic [31:0]      rd_b
);
    import rvh_pkg::*;

    logic [31:0] mem_a [32];
    logic [31:0] mem_b [32];
    logic [31:0] vld_reg;
    logic [31:0] a_q;
    logic [31:0] b_q;
    logic        va_q;
    logic        vb_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (req.we)
        begin
            vld_reg[req.wa] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_a[req.wa] <= req.wd;
            mem_b[req.wa] <= req.wd;
        end
        if (req.rd_en)
        begin
            a_q  <= mem_a[req.ra_a];
            b_q  <= mem_b[req.ra_b];
            va_q <= vld_reg[req.ra_a];
            vb_q <= vld_reg[req.ra_b];
        end
    end

    assign rd_a = va_q ? a_q : 32'h0;
    assign rd_b = vb_q ? b_q : 32'h0;

endmodule

/* src/rv32i_subset_hart_step.sv */
// top level of the rv32i subset hart
// A tick runs fetch from the byte memory, register read and execute; a load needs a second
// pass through the same memory port. A tick while halted or misaligned and a preload word
// finish on acceptance; a read word adds one memory read. The result is registered and
// handed on through a one-word stage, so the next word is taken while a result still waits.
// Memory contents are undefined until preloaded; the register file reads zero after reset.
module rv32i_subset_hart_step (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [15:0] mem_addr,
    input  logic [31:0] mem_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] pc_now,
    output logic        halted,
    output logic [1:0]  halt_code,
    output logic [31:0] retired,
    output logic        wb_valid,
    output logic [4:0]  wb_reg,
    output logic [31:0] wb_value,
    output logic [31:0] read_data
);
    import rvh_pkg::*;

    state_t      st_reg, st_next;
    logic [31:0] pc_reg, pc_next;
    logic        halt_reg, halt_next;
    logic [1:0]  code_reg, code_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] insn_reg;

    mem_req_t    mreq;
    logic [31:0] mrdata;
    rf_req_t     rreq;
    logic [31:0] ra;
    logic [31:0] rb;

    logic        acc;
    logic        fin;
    logic        wbv;
    logic [4:0]  wbr;
    logic [31:0] wbd;
    logic [31:0] rdd;

    logic        res_valid_reg;
    logic [31:0] res_pc_reg, res_cnt_reg, res_wbd_reg, res_rdd_reg;
    logic        res_halt_reg, res_wbv_reg;
    logic [1:0]  res_code_reg;
    logic [4:0]  res_wbr_reg;
    logic        out_valid_reg;
    logic        move;

    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [31:0] imm_i, imm_s, imm_u, imm_b, imm_j;
    logic        load_go;

    rvh_mem u_mem (
        .clk   (clk),
        .req   (mreq),
        .rdata (mrdata)
    );

    rvh_rf u_rf (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rreq),
        .rd_a  (ra),
        .rd_b  (rb)
    );

    assign in_ready = (st_reg == ST_IDLE) && (!res_valid_reg || move);
    assign acc      = in_valid && in_ready;
    assign move     = res_valid_reg && (!out_valid_reg || out_ready);

    assign opc   = insn_reg[6:0];
    assign rd    = insn_reg[11:7];
    assign f3    = insn_reg[14:12];
    assign imm_i = {{20{insn_reg[31]}}, insn_reg[31:20]};
    assign imm_s = {{20{insn_reg[31]}}, insn_reg[31:25], insn_reg[11:7]};
    assign imm_u = {insn_reg[31:12], 12'h000};
    assign imm_b = {{19{insn_reg[31]}}, insn_reg[31], insn_reg[7], insn_reg[30:25],
                    insn_reg[11:8], 1'b0};
    assign imm_j = {{11{insn_reg[31]}}, insn_reg[31], insn_reg[19:12], insn_reg[20],
                    insn_reg[30:21], 1'b0};
    assign load_go = (opc == OPC_LOAD) && (f3 == F3_B || f3 == F3_H || f3 == F3_W
                     || f3 == F3_BU || f3 == F3_HU);

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (acc && op == OP_READ)
                begin
                    st_next = ST_RDMEM;
                end
                else if (acc && op == OP_TICK && !halt_reg && pc_reg[1:0] == 2'b00)
                begin
                    st_next = ST_FETCH;
                end
            end
            ST_FETCH: st_next = ST_EXEC;
            ST_EXEC:  st_next = load_go ? ST_LOAD : ST_IDLE;
            ST_RDMEM: st_next = ST_IDLE;
            ST_LOAD:  st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        logic        take;
        logic        illegal;
        logic        dowb;
        logic [31:0] val;
        logic [31:0] nxt;

        mreq      = '0;
        rreq      = '0;
        fin       = 1'b0;
        pc_next   = pc_reg;
        halt_next = halt_reg;
        code_next = code_reg;
        cnt_next  = cnt_reg;
        wbv       = 1'b0;
        wbr       = 5'd0;
        wbd       = 32'h0;
        rdd       = 32'h0;
        take      = 1'b0;
        illegal   = 1'b0;
        dowb      = 1'b0;
        val       = 32'h0;
        nxt       = pc_reg + 32'd4;

        rreq.ra_a = mrdata[19:15];
        rreq.ra_b = mrdata[24:20];

        case (st_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    case (op)
                        OP_TICK:
                        begin
                            if (halt_reg)
                            begin
                                fin = 1'b1;
                            end
                            else if (pc_reg[1:0] != 2'b00)
                            begin
                                fin       = 1'b1;
                                halt_next = 1'b1;
                                code_next = HALT_ALIGN;
                            end
                            else
                            begin
                                mreq.rd_en = 1'b1;
                                mreq.addr  = pc_reg;
                            end
                        end
                        OP_PRELOAD:
                        begin
                            fin          = 1'b1;
                            mreq.wr_en   = 1'b1;
                            mreq.wr_mask = 4'hf;
                            mreq.addr    = {16'h0, mem_addr[15:2], 2'b00};
                            mreq.wr_data = mem_data;
                        end
                        OP_READ:
                        begin
                            mreq.rd_en = 1'b1;
                            mreq.addr  = {16'h0, mem_addr[15:2], 2'b00};
                        end
                        default: fin = 1'b1;
                    endcase
                end
            end
            ST_RDMEM:
            begin
                fin = 1'b1;
                rdd = mrdata;
            end
            ST_FETCH:
            begin
                rreq.rd_en = 1'b1;
            end
            ST_EXEC:
            begin
                cnt_next = cnt_reg + 32'd1;
                case (opc)
                    OPC_LUI:
                    begin
                        val  = imm_u;
                        dowb = 1'b1;
                    end
                    OPC_AUIPC:
                    begin
                        val  = pc_reg + imm_u;
                        dowb = 1'b1;
                    end
                    OPC_JAL:
                    begin
                        val  = pc_reg + 32'd4;
                        dowb = 1'b1;
                        nxt  = pc_reg + imm_j;
                    end
                    OPC_JALR:
                    begin
                        val  = pc_reg + 32'd4;
                        dowb = 1'b1;
                        nxt  = (ra + imm_i) & 32'hffff_fffe;
                    end
                    OPC_BRANCH:
                    begin
                        case (f3)
                            F3_BEQ:  take = ra == rb;
                            F3_BNE:  take = ra != rb;
                            F3_BLT:  take = $signed(ra) < $signed(rb);
                            F3_BGE:  take = !($signed(ra) < $signed(rb));
                            F3_BLTU: take = ra < rb;
                            F3_BGEU: take = ra >= rb;
                            default: illegal = 1'b1;
                        endcase
                        if (take)
                        begin
                            nxt = pc_reg + imm_b;
                        end
                    end
                    OPC_OPIMM:
                    begin
                        if (f3 == F3_ADDI)
                        begin
                            val  = ra + imm_i;
                            dowb = 1'b1;
                        end
                        else
                        begin
                            illegal = 1'b1;
                        end
                    end
                    OPC_LOAD:
                    begin
                        if (load_go)
                        begin
                            mreq.rd_en = 1'b1;
                            mreq.addr  = ra + imm_i;
                        end
                        else
                        begin
                            illegal = 1'b1;
                        end
                    end
                    OPC_STORE:
                    begin
                        mreq.addr    = ra + imm_s;
                        mreq.wr_data = rb;
                        case (f3)
                            F3_B:
                            begin
                                mreq.wr_en   = 1'b1;
                                mreq.wr_mask = 4'h1;
                            end
                            F3_H:
                            begin
                                mreq.wr_en   = 1'b1;
                                mreq.wr_mask = 4'h3;
                            end
                            F3_W:
                            begin
                                mreq.wr_en   = 1'b1;
                                mreq.wr_mask = 4'hf;
                            end
                            default: illegal = 1'b1;
                        endcase
                    end
                    default: illegal = 1'b1;
                endcase

                if (illegal)
                begin
                    fin       = 1'b1;
                    halt_next = 1'b1;
                    code_next = HALT_ILLEGAL;
                end
                else if (!load_go)
                begin
                    fin     = 1'b1;
                    pc_next = nxt;
                    if (dowb && rd != 5'd0)
                    begin
                        rreq.we = 1'b1;
                        rreq.wa = rd;
                        rreq.wd = val;
                        wbv     = 1'b1;
                        wbr     = rd;
                        wbd     = val;
                    end
                end
            end
            ST_LOAD:
            begin
                fin     = 1'b1;
                pc_next = nxt;
                case (f3)
                    F3_B:    val = {{24{mrdata[7]}}, mrdata[7:0]};
                    F3_H:    val = {{16{mrdata[15]}}, mrdata[15:0]};
                    F3_BU:   val = {24'h0, mrdata[7:0]};
                    F3_HU:   val = {16'h0, mrdata[15:0]};
                    default: val = mrdata;
                endcase
                if (rd != 5'd0)
                begin
                    rreq.we = 1'b1;
                    rreq.wa = rd;
                    rreq.wd = val;
                    wbv     = 1'b1;
                    wbr     = rd;
                    wbd     = val;
                end
            end
            default: fin = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            pc_reg        <= 32'h0;
            halt_reg      <= 1'b0;
            code_reg      <= HALT_NONE;
            cnt_reg       <= 32'h0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            pc_reg   <= pc_next;
            halt_reg <= halt_next;
            code_reg <= code_next;
            cnt_reg  <= cnt_next;
            if (fin)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                res_valid_reg <= 1'b0;
            end
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_FETCH)
        begin
            insn_reg <= mrdata;
        end
        if (fin)
        begin
            res_pc_reg   <= pc_next;
            res_halt_reg <= halt_next;
            res_code_reg <= code_next;
            res_cnt_reg  <= cnt_next;
            res_wbv_reg  <= wbv;
            res_wbr_reg  <= wbr;
            res_wbd_reg  <= wbd;
            res_rdd_reg  <= rdd;
        end
        if (move)
        begin
            pc_now    <= res_pc_reg;
            halted    <= res_halt_reg;
            halt_code <= res_code_reg;
            retired   <= res_cnt_reg;
            wb_valid  <= res_wbv_reg;
            wb_reg    <= res_wbr_reg;
            wb_value  <= res_wbd_reg;
            read_data <= res_rdd_reg;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared");

    a_fetch_exec: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_FETCH |=> st_reg == ST_EXEC)
        else $error("fetch not followed by execute");

    a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
        rreq.we |-> rreq.wa != 5'd0)
        else $error("write to x0");

    a_fin_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        fin |-> (!res_valid_reg || move))
        else $error("result stage overrun");
`endif

endmodule
